// ===== rtl/ddaim_pkg.sv =====
// Shared types, constants and the arctangent table for the differential drive aim block.
// No dependencies; the top level, ddaim_csr and ddaim_cordic import this package.
`default_nettype none

package ddaim_pkg;

   // Parameter defaults
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int COORD_BITS_DEF    = 12;

   // Arctangent table length; stages past it use a zero angle
   localparam int ANG_TABLE_LEN = 24;

   // Coordinate differences are scaled to a fixed 2^40 full scale
   localparam int SCALE_BITS = 40;

   // 1/K gain of the rotation CORDIC in Q1.30
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;

   // ceil(2^40 / 360): degrees to binary angle by reciprocal multiply
   localparam logic [31:0] HEAD_RECIP = 32'd3054198967;
   localparam int          HEAD_SHIFT = 40;

   // Half of 360 for rounding the heading conversion
   localparam logic [7:0] HEAD_HALF_DEG = 8'd180;

   // Wheel speed constants
   localparam logic signed [7:0] SPEED_FULL = 8'sd100;
   localparam logic signed [7:0] SPEED_SPIN = 8'sd30;
   localparam logic [6:0]        SPEED_MULT = 7'd100;

   // Angle constants (16-bit and 32-bit binary angles)
   localparam logic [15:0] ANG_QUARTER     = 16'h4000;
   localparam logic [15:0] ANG_HALF        = 16'h8000;
   localparam logic [15:0] ANG_THREE_QUART = 16'hC000;
   localparam logic [31:0] ANG32_HALF      = 32'h8000_0000;
   localparam logic [31:0] ANG32_ROUND     = 32'h0000_8000;

   // Cosine rounding and limits (Q1.15)
   localparam logic [15:0] COS_ONE = 16'h8000;

   // Register map
   typedef enum logic {
      REG_REVERSE_MODE = 1'b0
   } csr_reg_type;

   // Pipeline control into a CORDIC unit
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] ang_tab(input int idx);
      logic [31:0] a;
      case (idx)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ddaim_if.sv =====
// Valid/ready channel interfaces for pose/target beats and wheel speed beats.
// No dependencies.
`default_nettype none

interface ddaim_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pos_x;
   logic [11:0] pos_y;
   logic [8:0]  heading_deg;
   logic [11:0] goal_x;
   logic [11:0] goal_y;

   modport source (output valid, pos_x, pos_y, heading_deg, goal_x, goal_y, input ready);
   modport sink   (input valid, pos_x, pos_y, heading_deg, goal_x, goal_y, output ready);
endinterface

interface ddaim_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] left_speed;
   logic signed [7:0] right_speed;

   modport source (output valid, left_speed, right_speed, input ready);
   modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

`default_nettype wire

// ===== rtl/differential_drive_aim_top.sv =====
// Top level of the differential drive aim block: bearing CORDIC, heading error, cosine CORDIC.
// Depends on ddaim_pkg, ddaim_if, ddaim_csr and ddaim_cordic.
// Path of a request beat: stages 1 and 2, bearing CORDIC, stage 3, cosine CORDIC, stage 4, output register.
// Throughput: one beat per cycle; the whole pipeline holds while the response is stalled.
// Each CORDIC iteration has its own register stage, so both units take a new beat every cycle unless stalled.
// Reset (synchronous, active high) clears all valid bits and sets reverse_mode to 0.
`default_nettype none

module differential_drive_aim_top #(
   parameter int CORDIC_STAGES = ddaim_pkg::CORDIC_STAGES_DEF,
   parameter int COORD_BITS    = ddaim_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   ddaim_req_if.sink          req_bus,
   ddaim_rsp_if.source        rsp_bus,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import ddaim_pkg::*;

   localparam int VW  = SCALE_BITS + 4;   // vectoring datapath
   localparam int RW  = 34;               // rotation datapath
   localparam int RZW = 33;
   localparam int DW  = COORD_BITS + 1;   // coordinate difference
   localparam int NW  = 25;               // deg*65536+180
   localparam int PW  = NW + 32;

   logic         reverse_mode;
   logic         advance;
   pipe_ctl_type vec_ctl;
   pipe_ctl_type rot_ctl;

   ddaim_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .reverse_mode (reverse_mode)
   );

   // Global stall: everything moves when the output register is free
   logic rsp_valid_ff;
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Stage 1: coordinate differences and heading numerator
   logic [15:0]          px_ext, py_ext, gx_ext, gy_ext;
   logic signed [DW-1:0] dx_in, dy_in;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [NW-1:0]        n_ff;
   logic                 v1_ff;

   assign px_ext = 16'(req_bus.pos_x);
   assign py_ext = 16'(req_bus.pos_y);
   assign gx_ext = 16'(req_bus.goal_x);
   assign gy_ext = 16'(req_bus.goal_y);
   assign dx_in  = $signed({1'b0, gx_ext[COORD_BITS-1:0]}) -
                   $signed({1'b0, px_ext[COORD_BITS-1:0]});
   assign dy_in  = $signed({1'b0, gy_ext[COORD_BITS-1:0]}) -
                   $signed({1'b0, py_ext[COORD_BITS-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         n_ff  <= {req_bus.heading_deg, 16'd0} + NW'(HEAD_HALF_DEG);
      end
   end

   // Stage 2: heading by reciprocal multiply, CORDIC seed in the right half plane
   logic [PW-1:0]        head_prod;
   logic signed [VW-1:0] sx, sy;
   logic [15:0]          head_ff;
   logic                 zero_ff;
   logic signed [VW-1:0] vx_ff, vy_ff;
   logic signed [31:0]   vz_ff;
   logic                 v2_ff;

   assign head_prod = PW'(n_ff) * PW'(HEAD_RECIP);
   assign sx        = VW'(dx_ff) <<< (SCALE_BITS - COORD_BITS);
   assign sy        = VW'(dy_ff) <<< (SCALE_BITS - COORD_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_ff <= head_prod[HEAD_SHIFT+15:HEAD_SHIFT];
         zero_ff <= (dx_ff == '0) && (dy_ff == '0);
         if (dx_ff[DW-1]) begin
            vx_ff <= -sx;
            vy_ff <= -sy;
            vz_ff <= ANG32_HALF;
         end else begin
            vx_ff <= sx;
            vy_ff <= sy;
            vz_ff <= '0;
         end
      end
   end

   // Bearing CORDIC
   logic                 vec_valid;
   logic signed [VW-1:0] vec_x, vec_y;
   logic signed [31:0]   vec_z;
   logic [16:0]          vec_side;

   assign vec_ctl = '{advance: advance, valid: v2_ff};

   ddaim_cordic #(
      .STAGES    (CORDIC_STAGES),
      .W         (VW),
      .ZW        (32),
      .SW        (17),
      .VECTORING (1'b1)
   ) u_vec (
      .clock   (clock),
      .reset   (reset),
      .ctl     (vec_ctl),
      .x_i     (vx_ff),
      .y_i     (vy_ff),
      .z_i     (vz_ff),
      .side_i  ({zero_ff, head_ff}),
      .valid_o (vec_valid),
      .x_o     (vec_x),
      .y_o     (vec_y),
      .z_o     (vec_z),
      .side_o  (vec_side)
   );

   // Stage 3: heading error, direction class and cosine angle
   logic [31:0]           brg_round;
   logic [15:0]           brg, e16, cos_ang;
   logic                  ahead, err_pos;
   logic signed [RZW-1:0] rz_ff;
   logic [1:0]            cls_ff;
   logic                  v3_ff;

   assign brg_round = $unsigned(vec_z) + ANG32_ROUND;
   assign brg       = vec_side[16] ? 16'd0 : brg_round[31:16];
   assign e16       = vec_side[15:0] - brg;
   // half turn counts as +pi; exactly a quarter turn is behind
   assign err_pos   = (e16 != 16'd0) && (!e16[15] || (e16 == ANG_HALF));
   assign ahead     = (e16 < ANG_QUARTER) || (e16 > ANG_THREE_QUART);
   assign cos_ang   = ahead ? e16 : (e16 ^ ANG_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= vec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rz_ff  <= {cos_ang[15], cos_ang, 16'd0};
         cls_ff <= {ahead, err_pos};
      end
   end

   // Cosine CORDIC
   logic                  rot_valid;
   logic signed [RW-1:0]  rot_x, rot_y;
   logic signed [RZW-1:0] rot_z;
   logic [1:0]            rot_side;

   assign rot_ctl = '{advance: advance, valid: v3_ff};

   ddaim_cordic #(
      .STAGES    (CORDIC_STAGES),
      .W         (RW),
      .ZW        (RZW),
      .SW        (2),
      .VECTORING (1'b0)
   ) u_rot (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rot_ctl),
      .x_i     (RW'(GAIN_Q30)),
      .y_i     ('0),
      .z_i     (rz_ff),
      .side_i  (cls_ff),
      .valid_o (rot_valid),
      .x_o     (rot_x),
      .y_o     (rot_y),
      .z_o     (rot_z),
      .side_o  (rot_side)
   );

   // Stage 4: round cosine to Q1.15 and clamp to 0..1
   logic signed [RW-1:0] cx;
   logic signed [RW-1:0] cs;
   logic [15:0]          cos_in, cos_ff;
   logic [1:0]           cls4_ff;
   logic                 v4_ff;

   assign cx = rot_x + RW'(16384);
   assign cs = cx >>> 15;

   always_comb begin
      if (cs[RW-1]) begin
         cos_in = 16'd0;
      end else if (cs > $signed(RW'(COS_ONE))) begin
         cos_in = COS_ONE;
      end else begin
         cos_in = cs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff  <= cos_in;
         cls4_ff <= rot_side;
      end
   end

   // Stage 5: inner wheel speed and wheel selection into the output register
   logic [22:0]       inner_prod;
   logic signed [7:0] inner;
   logic signed [7:0] left_in, right_in;
   logic signed [7:0] left_ff, right_ff;

   assign inner_prod = 23'(cos_ff) * 23'(SPEED_MULT);
   assign inner      = $signed({1'b0, inner_prod[21:15]});

   always_comb begin
      if (cls4_ff[1]) begin
         left_in  = cls4_ff[0] ? inner : SPEED_FULL;
         right_in = cls4_ff[0] ? SPEED_FULL : inner;
      end else if (!reverse_mode) begin
         left_in  = cls4_ff[0] ? -SPEED_SPIN : SPEED_SPIN;
         right_in = cls4_ff[0] ? SPEED_SPIN : -SPEED_SPIN;
      end else begin
         left_in  = cls4_ff[0] ? -inner : -SPEED_FULL;
         right_in = cls4_ff[0] ? -SPEED_FULL : -inner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_speed  = left_ff;
   assign rsp_bus.right_speed = right_ff;

   // Checks
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff >= -SPEED_FULL) && (left_ff <= SPEED_FULL) &&
                       (right_ff >= -SPEED_FULL) && (right_ff <= SPEED_FULL))
      else $error("wheel speed out of range");

   a_one_full_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff == SPEED_FULL) || (right_ff == SPEED_FULL) ||
                       (left_ff == -SPEED_FULL) || (right_ff == -SPEED_FULL) ||
                       ((left_ff == SPEED_SPIN) && (right_ff == -SPEED_SPIN)) ||
                       ((left_ff == -SPEED_SPIN) && (right_ff == SPEED_SPIN)))
      else $error("no wheel at full or spin speed");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v4_ff) && $stable(cos_ff) && $stable(v1_ff))
      else $error("pipeline moved during stall");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !v1_ff && !v4_ff)
      else $error("valid bit set after reset");

endmodule

`default_nettype wire

// ===== rtl/ddaim_csr.sv =====
// APB-style register file: holds the reverse_mode control bit.
// Depends on ddaim_pkg.
`default_nettype none

module ddaim_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        reverse_mode
);
   import ddaim_pkg::*;

   logic        reverse_mode_ff;
   logic        reverse_mode_in;
   logic        wr_en;
   csr_reg_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = csr_reg_type'(paddr[2]);

   // Write decode and read data
   always_comb begin
      reverse_mode_in = reverse_mode_ff;
      prdata          = 32'd0;
      unique case (reg_sel)
         REG_REVERSE_MODE: begin
            if (wr_en) reverse_mode_in = pwdata[0];
            prdata = {31'd0, reverse_mode_ff};
         end
         default: begin
            prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_mode_ff <= 1'b0;
      end else begin
         reverse_mode_ff <= reverse_mode_in;
      end
   end

   assign reverse_mode = reverse_mode_ff;

endmodule

`default_nettype wire

// ===== rtl/ddaim_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per register stage, vectoring or rotation.
// Depends on ddaim_pkg for the arctangent table and the control struct.
`default_nettype none

module ddaim_cordic #(
   parameter int STAGES    = ddaim_pkg::CORDIC_STAGES_DEF,
   parameter int W         = 44,
   parameter int ZW        = 32,
   parameter int SW        = 1,
   parameter bit VECTORING = 1'b1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ddaim_pkg::pipe_ctl_type ctl,
   input  logic signed [W-1:0]     x_i,
   input  logic signed [W-1:0]     y_i,
   input  logic signed [ZW-1:0]    z_i,
   input  logic [SW-1:0]           side_i,
   output logic                    valid_o,
   output logic signed [W-1:0]     x_o,
   output logic signed [W-1:0]     y_o,
   output logic signed [ZW-1:0]    z_o,
   output logic [SW-1:0]           side_o
);
   import ddaim_pkg::*;

   logic                 valid_ff [STAGES];
   logic signed [W-1:0]  x_ff     [STAGES];
   logic signed [W-1:0]  y_ff     [STAGES];
   logic signed [ZW-1:0] z_ff     [STAGES];
   logic [SW-1:0]        side_ff  [STAGES];

   genvar g;
   generate
      for (g = 0; g < STAGES; g++) begin : g_stage
         logic                 v_pre;
         logic signed [W-1:0]  x_pre;
         logic signed [W-1:0]  y_pre;
         logic signed [ZW-1:0] z_pre;
         logic [SW-1:0]        s_pre;
         logic signed [W-1:0]  xs;
         logic signed [W-1:0]  ys;
         logic signed [ZW-1:0] ang;
         logic                 turn_pos;

         if (g == 0) begin : g_first
            assign v_pre = ctl.valid;
            assign x_pre = x_i;
            assign y_pre = y_i;
            assign z_pre = z_i;
            assign s_pre = side_i;
         end else begin : g_next
            assign v_pre = valid_ff[g-1];
            assign x_pre = x_ff[g-1];
            assign y_pre = y_ff[g-1];
            assign z_pre = z_ff[g-1];
            assign s_pre = side_ff[g-1];
         end

         // Shifted operands and rotation direction
         assign xs       = x_pre >>> g;
         assign ys       = y_pre >>> g;
         assign ang      = ZW'(ang_tab(g));
         assign turn_pos = VECTORING ? y_pre[W-1] : !z_pre[ZW-1];

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[g] <= 1'b0;
            end else if (ctl.advance) begin
               valid_ff[g] <= v_pre;
            end
         end

         // Micro-rotation
         always_ff @(posedge clock) begin
            if (ctl.advance) begin
               side_ff[g] <= s_pre;
               if (turn_pos) begin
                  x_ff[g] <= x_pre - ys;
                  y_ff[g] <= y_pre + xs;
                  z_ff[g] <= z_pre - ang;
               end else begin
                  x_ff[g] <= x_pre + ys;
                  y_ff[g] <= y_pre - xs;
                  z_ff[g] <= z_pre + ang;
               end
            end
         end
      end
   endgenerate

   assign valid_o = valid_ff[STAGES-1];
   assign x_o     = x_ff[STAGES-1];
   assign y_o     = y_ff[STAGES-1];
   assign z_o     = z_ff[STAGES-1];
   assign side_o  = side_ff[STAGES-1];

endmodule

`default_nettype wire
